FILE: hdl/azlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// azlc_pkg
// Shared types and constants of the alarm zone loop classifier.
// ----------------------------------------------------------------------------
package azlc_pkg;

   localparam int NUM_ZONES       = 16;
   localparam int ZONES_PER_GROUP = 8;
   localparam int ZONE_W          = 4;
   localparam int SAMPLE_W        = 12;
   localparam int CSR_INDEX_W     = 3;
   localparam int MASK_W          = NUM_ZONES - ZONES_PER_GROUP;

   // last loop zone: its item checks the zones 0-2 rule
   localparam logic [ZONE_W-1:0] GROUP_LAST = ZONE_W'(ZONES_PER_GROUP - 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ALARM_LOW   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALARM_HIGH  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_LOW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_HIGH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TAMPER_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TAMPER_HIGH = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BREAK_LOW   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_NORMAL_MID  = 3'd7;

   // register reset values
   localparam logic [SAMPLE_W-1:0] RST_ALARM_LOW   = 12'd1000;
   localparam logic [SAMPLE_W-1:0] RST_ALARM_HIGH  = 12'd1500;
   localparam logic [SAMPLE_W-1:0] RST_NORMAL_LOW  = 12'd1800;
   localparam logic [SAMPLE_W-1:0] RST_NORMAL_HIGH = 12'd2300;
   localparam logic [SAMPLE_W-1:0] RST_TAMPER_LOW  = 12'd2500;
   localparam logic [SAMPLE_W-1:0] RST_TAMPER_HIGH = 12'd3000;
   localparam logic [SAMPLE_W-1:0] RST_BREAK_LOW   = 12'd3500;
   localparam logic [SAMPLE_W-1:0] RST_NORMAL_MID  = 12'd2048;

   typedef enum logic [1:0] {
      ST_NORMAL = 2'd0,
      ST_EVENT  = 2'd1,
      ST_TAMPER = 2'd2,
      ST_BREAK  = 2'd3
   } status_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] alarm_low;
      logic [SAMPLE_W-1:0] alarm_high;
      logic [SAMPLE_W-1:0] normal_low;
      logic [SAMPLE_W-1:0] normal_high;
      logic [SAMPLE_W-1:0] tamper_low;
      logic [SAMPLE_W-1:0] tamper_high;
      logic [SAMPLE_W-1:0] break_low;
   } thr_type;

endpackage

FILE: hdl/azlc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// azlc_req_if
// Sample channel: one zone index and its ADC reading per beat.
// ----------------------------------------------------------------------------
interface azlc_req_if;
   import azlc_pkg::*;

   logic                valid;
   logic                ready;
   logic [ZONE_W-1:0]   zone;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output zone, output sample, input ready);
   modport sink   (input valid, input zone, input sample, output ready);
endinterface

FILE: hdl/azlc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// azlc_rsp_if
// Status channel: zone status, group rule flags and opto mask per beat.
// ----------------------------------------------------------------------------
interface azlc_rsp_if;
   import azlc_pkg::*;

   logic              valid;
   logic              ready;
   logic [ZONE_W-1:0] zone_out;
   logic [1:0]        status;
   logic              group_override;
   logic              emergency_new;
   logic [MASK_W-1:0] opto_mask;

   modport source (output valid, output zone_out, output status, output group_override,
                   output emergency_new, output opto_mask, input ready);
   modport sink   (input valid, input zone_out, input status, input group_override,
                   input emergency_new, input opto_mask, output ready);
endinterface

FILE: hdl/azlc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// azlc_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module azlc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/azlc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// azlc_classify
// Stability test and window sort of one sample against its previous value.
// ----------------------------------------------------------------------------
module azlc_classify (
   input  azlc_pkg::thr_type              thr,
   input  logic                           is_loop,
   input  logic [azlc_pkg::SAMPLE_W-1:0]  sample,
   input  logic [azlc_pkg::SAMPLE_W-1:0]  prev,
   input  azlc_pkg::status_type           cur_status,
   output azlc_pkg::status_type           new_status
);
   import azlc_pkg::*;

   logic [SAMPLE_W:0]   two_s;
   logic [SAMPLE_W+3:0] ten_s;
   logic [SAMPLE_W+3:0] eleven_prev;
   logic                stable;
   logic                in_alarm;
   logic                in_normal;
   logic                in_tamper;
   logic                is_brk;

   // 0.5*prev < s < 1.1*prev, done as 2*s > prev and 10*s < 11*prev
   assign two_s       = {sample, 1'b0};
   assign ten_s       = {1'b0, sample, 3'b000} + {3'b000, sample, 1'b0};
   assign eleven_prev = {1'b0, prev, 3'b000} + {3'b000, prev, 1'b0} + {4'b0000, prev};
   assign stable      = (two_s > {1'b0, prev}) && (ten_s < eleven_prev);

   assign in_alarm  = (sample >= thr.alarm_low)  && (sample <= thr.alarm_high);
   assign in_normal = (sample >= thr.normal_low) && (sample <= thr.normal_high);
   assign in_tamper = (sample >= thr.tamper_low) && (sample <= thr.tamper_high);
   assign is_brk    = (sample < thr.alarm_low)   || (sample >= thr.break_low);

   always_comb begin
      new_status = cur_status;
      if (is_loop) begin
         if (stable) begin
            if (in_alarm) begin
               new_status = ST_EVENT;
            end else if (in_normal) begin
               new_status = ST_NORMAL;
            end else if (in_tamper) begin
               new_status = ST_TAMPER;
            end else if (is_brk) begin
               new_status = ST_BREAK;
            end
         end else if (is_brk) begin
            new_status = ST_BREAK;
         end
      end else if (stable) begin
         new_status = (sample <= thr.alarm_high) ? ST_EVENT : ST_NORMAL;
      end
   end
endmodule

FILE: hdl/alarm_zone_loop_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_zone_loop_classifier
// Per-zone sample classifier: previous samples in RAM, zone status in flops.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      beat contents
//  req_bus  in   valid/ready    zone, sample
//  rsp_bus  out  valid/ready    zone_out, status, group_override,
//                               emergency_new, opto_mask
//  csr_*    in   csr_we         csr_index, csr_wdata (write only)
//
//  one beat per cycle sustained while rsp_bus.ready holds; req passes through stage 1 and the output register
//  stage 1 reads the previous sample from RAM and writes the new one (read-first)
//  stage 2 classifies, updates zone status and loads the output register
//  after reset all previous samples read as the preset 2048 via per-zone valid bits
//  rsp stall holds the output register; req keeps flowing while stage 2 can drain
// ----------------------------------------------------------------------------
module alarm_zone_loop_classifier (
   input  logic                             clock,
   input  logic                             reset,
   azlc_req_if.sink                         req_bus,
   azlc_rsp_if.source                       rsp_bus,
   input  logic                             csr_we,
   input  logic [azlc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [azlc_pkg::SAMPLE_W-1:0]    csr_wdata
);
   import azlc_pkg::*;

   thr_type             thr_ff, thr_in;
   logic [NUM_ZONES-1:0] prev_vld_ff, prev_vld_in;

   logic                req_fire;
   logic                s1_adv;
   logic                s1_valid_ff, s1_valid_in;
   logic [ZONE_W-1:0]   s1_zone_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_pvld_ff;

   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SAMPLE_W-1:0] prev;
   status_type          cur_status;
   status_type          cls_status;
   logic                override;
   logic                em_new;
   logic                emergency_ff, emergency_in;
   status_type          status_ff [NUM_ZONES];
   status_type          status_in [NUM_ZONES];
   logic [MASK_W-1:0]   mask_next;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ZONE_W-1:0]   rsp_zone_ff;
   logic [1:0]          rsp_status_ff;
   logic                rsp_ovr_ff;
   logic                rsp_em_ff;
   logic [MASK_W-1:0]   rsp_mask_ff;

   // ---------------- configuration ----------------
   always_comb begin
      thr_in = thr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ALARM_LOW:   thr_in.alarm_low   = csr_wdata;
            REG_ALARM_HIGH:  thr_in.alarm_high  = csr_wdata;
            REG_NORMAL_LOW:  thr_in.normal_low  = csr_wdata;
            REG_NORMAL_HIGH: thr_in.normal_high = csr_wdata;
            REG_TAMPER_LOW:  thr_in.tamper_low  = csr_wdata;
            REG_TAMPER_HIGH: thr_in.tamper_high = csr_wdata;
            REG_BREAK_LOW:   thr_in.break_low   = csr_wdata;
            // the mid preset only matters at reset, so a later write has no effect
            REG_NORMAL_MID:  thr_in = thr_ff;
            default:         thr_in = thr_ff;
         endcase
      end
   end

   // ---------------- stage 1: RAM access ----------------
   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      prev_vld_in = prev_vld_ff;
      if (req_fire) begin
         prev_vld_in[req_bus.zone] = 1'b1;
      end
   end

   azlc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (NUM_ZONES)
   ) u_prev_ram (
      .clock (clock),
      .we    (req_fire),
      .waddr (req_bus.zone),
      .wdata (req_bus.sample),
      .re    (req_fire),
      .raddr (req_bus.zone),
      .rdata (ram_rdata)
   );

   // ---------------- stage 2: classify and update ----------------
   assign prev       = s1_pvld_ff ? ram_rdata : RST_NORMAL_MID;
   assign cur_status = status_ff[s1_zone_ff];

   azlc_classify u_classify (
      .thr        (thr_ff),
      .is_loop    (s1_zone_ff < ZONE_W'(ZONES_PER_GROUP)),
      .sample     (s1_sample_ff),
      .prev       (prev),
      .cur_status (cur_status),
      .new_status (cls_status)
   );

   // zones 0-2 change only on their own items or the override, so the flops are current here
   assign override = (s1_zone_ff == GROUP_LAST) &&
                     (status_ff[0] == ST_BREAK) && (status_ff[1] == ST_BREAK) &&
                     (status_ff[2] == ST_BREAK);
   assign em_new   = override && !emergency_ff;

   always_comb begin
      status_in    = status_ff;
      emergency_in = emergency_ff;
      if (s1_adv) begin
         status_in[s1_zone_ff] = cls_status;
         if (override) begin
            status_in[0]          = ST_EVENT;
            status_in[1]          = ST_EVENT;
            status_in[2]          = ST_EVENT;
            status_in[GROUP_LAST] = ST_BREAK;
            emergency_in          = 1'b1;
         end
      end
      // zone 8 lands in the top mask bit
      for (int i = 0; i < MASK_W; i++) begin
         mask_next[MASK_W-1-i] = (status_in[ZONES_PER_GROUP+i] != ST_NORMAL);
      end
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '{alarm_low:   RST_ALARM_LOW,   alarm_high:  RST_ALARM_HIGH,
                           normal_low:  RST_NORMAL_LOW,  normal_high: RST_NORMAL_HIGH,
                           tamper_low:  RST_TAMPER_LOW,  tamper_high: RST_TAMPER_HIGH,
                           break_low:   RST_BREAK_LOW};
         prev_vld_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emergency_ff <= 1'b0;
         for (int i = 0; i < NUM_ZONES; i++) begin
            status_ff[i] <= ST_NORMAL;
         end
      end else begin
         thr_ff       <= thr_in;
         prev_vld_ff  <= prev_vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         emergency_ff <= emergency_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_zone_ff   <= req_bus.zone;
         s1_sample_ff <= req_bus.sample;
         s1_pvld_ff   <= prev_vld_ff[req_bus.zone];
      end
      if (s1_adv) begin
         rsp_zone_ff   <= s1_zone_ff;
         rsp_status_ff <= status_in[s1_zone_ff];
         rsp_ovr_ff    <= override;
         rsp_em_ff     <= em_new;
         rsp_mask_ff   <= mask_next;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.zone_out       = rsp_zone_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.group_override = rsp_ovr_ff;
   assign rsp_bus.emergency_new  = rsp_em_ff;
   assign rsp_bus.opto_mask      = rsp_mask_ff;

   // ---------------- checks ----------------
   a_override_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovr_ff |-> rsp_zone_ff == GROUP_LAST)
      else $error("group override on a zone other than the last loop zone");

   a_em_needs_override: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_em_ff |-> rsp_ovr_ff && emergency_ff)
      else $error("emergency flag without group override or latch");

   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      emergency_ff |=> emergency_ff)
      else $error("emergency latch cleared without reset");

   a_override_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv && override |=> status_ff[0] == ST_EVENT && status_ff[GROUP_LAST] == ST_BREAK)
      else $error("group rule did not rewrite zone status");
endmodule
